// ----- rtl/core/cmdack_pkg.sv -----
// ----------------------------------------------------------------------------
// cmdack_pkg
// Shared types, codes and reset values of the command/ACK retry engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cmdack_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned OB_DEPTH        = 4;
  localparam int unsigned OB_PTRW         = $clog2(OB_DEPTH);
  localparam int unsigned OB_CNTW         = $clog2(OB_DEPTH + 1);

  localparam logic [15:0] ACK_TIMEOUT_RST    = 16'd500;
  localparam logic [2:0]  MAX_ATTEMPTS_RST   = 3'd3;
  localparam logic [15:0] ONLINE_TIMEOUT_RST = 16'd15000;
  localparam logic [7:0]  CTRL_TYPE_RST      = 8'd1;
  localparam logic [7:0]  ACK_TYPE_RST       = 8'd2;
  localparam logic [7:0]  NACK_TYPE_RST      = 8'd3;
  localparam logic [15:0] NEXT_SEQ_RST       = 16'd1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_FRAME  = 2'd1,
    OP_SUBMIT = 2'd2,
    OP_POLL   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_TX       = 2'd0,
    KIND_RESULT   = 2'd1,
    KIND_ACCEPTED = 2'd2,
    KIND_POLL     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RC_OK         = 3'd0,
    RC_REJECTED   = 3'd1,
    RC_TIMEOUT    = 3'd2,
    RC_OFFLINE    = 3'd3,
    RC_QUEUE_FULL = 3'd4
  } rcode_e;

  typedef enum logic [2:0] {
    CFG_ACK_TIMEOUT    = 3'd0,
    CFG_MAX_ATTEMPTS   = 3'd1,
    CFG_ONLINE_TIMEOUT = 3'd2,
    CFG_CTRL_TYPE      = 3'd3,
    CFG_ACK_TYPE       = 3'd4,
    CFG_NACK_TYPE      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] ack_timeout;
    logic [2:0]  max_attempts;
    logic [15:0] online_timeout;
    logic [7:0]  ctrl_type;
    logic [7:0]  ack_type;
    logic [7:0]  nack_type;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  frame_type;
    logic [7:0]  frame_length;
    logic [7:0]  frame_first_byte;
    logic [7:0]  frame_second_byte;
    logic [15:0] frame_sequence;
    logic [7:0]  command_id;
  } item_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  id;
  } pend_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    pend_t data;
  } q_ctl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sequence_res;
    logic [7:0]  result_id;
    logic [2:0]  attempts;
    logic [2:0]  result_code;
    logic        link_lost;
    logic        last;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } res_wr_t;

  function automatic res_t mk_res(kind_e kind, logic [15:0] seq, logic [7:0] id,
                                  logic [2:0] att, rcode_e code, logic lost);
    res_t r;
    r.kind         = kind;
    r.sequence_res = seq;
    r.result_id    = id;
    r.attempts     = att;
    r.result_code  = code;
    r.link_lost    = lost;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cmdack_if.sv -----
// ----------------------------------------------------------------------------
// cmdack_if
// Valid/ready channels of the engine: event input, result output, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmdack_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  frame_type;
  logic [7:0]  frame_length;
  logic [7:0]  frame_first_byte;
  logic [7:0]  frame_second_byte;
  logic [15:0] frame_sequence;
  logic [7:0]  command_id;

  modport source (
    output valid, opcode, frame_type, frame_length, frame_first_byte,
           frame_second_byte, frame_sequence, command_id,
    input  ready
  );
  modport sink (
    input  valid, opcode, frame_type, frame_length, frame_first_byte,
           frame_second_byte, frame_sequence, command_id,
    output ready
  );
endinterface

interface cmdack_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] sequence_res;
  logic [7:0]  result_id;
  logic [2:0]  attempts;
  logic [2:0]  result_code;
  logic        link_lost;
  logic        last;

  modport source (
    output valid, kind, sequence_res, result_id, attempts, result_code,
           link_lost, last,
    input  ready
  );
  modport sink (
    input  valid, kind, sequence_res, result_id, attempts, result_code,
           link_lost, last,
    output ready
  );
endinterface

interface cmdack_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cmdack_cfg.sv -----
// ----------------------------------------------------------------------------
// cmdack_cfg
// Configuration register file, written over the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cmdack_cfg import cmdack_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cmdack_cfg_if.sink cfg_i,
  output cfg_t cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_timeout    <= ACK_TIMEOUT_RST;
      cfg_q.max_attempts   <= MAX_ATTEMPTS_RST;
      cfg_q.online_timeout <= ONLINE_TIMEOUT_RST;
      cfg_q.ctrl_type      <= CTRL_TYPE_RST;
      cfg_q.ack_type       <= ACK_TYPE_RST;
      cfg_q.nack_type      <= NACK_TYPE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ACK_TIMEOUT:    cfg_q.ack_timeout    <= cfg_i.data;
        CFG_MAX_ATTEMPTS:   cfg_q.max_attempts   <= cfg_i.data[2:0];
        CFG_ONLINE_TIMEOUT: cfg_q.online_timeout <= cfg_i.data;
        CFG_CTRL_TYPE:      cfg_q.ctrl_type      <= cfg_i.data[7:0];
        CFG_ACK_TYPE:       cfg_q.ack_type       <= cfg_i.data[7:0];
        CFG_NACK_TYPE:      cfg_q.nack_type      <= cfg_i.data[7:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cmdack_queue.sv -----
// ----------------------------------------------------------------------------
// cmdack_queue
// FIFO of pending commands with registered head read and write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module cmdack_queue import cmdack_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  q_ctl_t          ctl_i,
  output pend_t           head_o,
  output logic [CntW-1:0] count_o
);

  pend_t           mem [QUEUE_DEPTH];
  pend_t           head_q;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    rd_ptr_d = ctl_i.pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    wr_ptr_d = ctl_i.push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    cnt_d    = cnt_q;
    if (ctl_i.push) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctl_i.pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // head_q is loaded from the next read pointer, so it always holds the entry at the read pointer
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[wr_ptr_q] <= ctl_i.data;
    end
    if (ctl_i.push && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= ctl_i.data;
    end else begin
      head_q <= mem[rd_ptr_d];
    end
  end

  assign head_o  = head_q;
  assign count_o = cnt_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> (cnt_q < CntW'(QUEUE_DEPTH)))
    else $error("push into full command queue");

  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.push && ctl_i.pop))
    else $error("command queue pushed and popped in one cycle");

endmodule

`default_nettype wire

// ----- rtl/core/cmdack_outbuf.sv -----
// ----------------------------------------------------------------------------
// cmdack_outbuf
// Small result buffer: takes up to two results a cycle, drives one out.
// ----------------------------------------------------------------------------
`default_nettype none

module cmdack_outbuf import cmdack_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  res_wr_t wr_i,
  output logic    space_o,
  cmdack_out_if.source out_o
);

  res_t               res_mem [OB_DEPTH];
  logic [OB_PTRW-1:0] rd_ptr_q, wr_ptr_q;
  logic [OB_CNTW-1:0] cnt_q, n_wr;
  logic               rd;
  res_t               head;

  assign n_wr    = OB_CNTW'(wr_i.v0) + OB_CNTW'(wr_i.v1);
  assign rd      = out_o.valid && out_o.ready;
  assign space_o = cnt_q <= OB_CNTW'(OB_DEPTH - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_q + OB_PTRW'(rd);
      wr_ptr_q <= wr_ptr_q + OB_PTRW'(n_wr);
      cnt_q    <= cnt_q + n_wr - OB_CNTW'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.v0) begin
      res_mem[wr_ptr_q] <= wr_i.r0;
    end
    if (wr_i.v1) begin
      res_mem[wr_ptr_q + OB_PTRW'(1)] <= wr_i.r1;
    end
  end

  assign head               = res_mem[rd_ptr_q];
  assign out_o.valid        = cnt_q != '0;
  assign out_o.kind         = head.kind;
  assign out_o.sequence_res = head.sequence_res;
  assign out_o.result_id    = head.result_id;
  assign out_o.attempts     = head.attempts;
  assign out_o.result_code  = head.result_code;
  assign out_o.link_lost    = head.link_lost;
  assign out_o.last         = head.last;

  a_ob_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= OB_CNTW'(OB_DEPTH)) && !(wr_i.v1 && !wr_i.v0))
    else $error("result buffer overrun or out-of-order write");

endmodule

`default_nettype wire

// ----- rtl/core/cmdack_engine.sv -----
// ----------------------------------------------------------------------------
// cmdack_engine
// Input register and stop-and-wait control: submit, ACK match, timeout,
// retransmit and link watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

module cmdack_engine import cmdack_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  cmdack_in_if.sink       in_i,
  input  cfg_t            cfg_i,
  input  logic            space_i,
  input  pend_t           head_i,
  input  logic [CntW-1:0] pend_cnt_i,
  output q_ctl_t          q_ctl_o,
  output res_wr_t         res_wr_o
);

  item_t       item_q;
  logic        item_vld_q;
  logic        fire;

  logic [15:0] next_seq_q, next_seq_d;
  logic        busy_q, busy_d;
  logic [15:0] wait_seq_q, wait_seq_d;
  logic [7:0]  cur_id_q, cur_id_d;
  logic [2:0]  att_q, att_d;
  logic [15:0] ack_timer_q, ack_timer_d;
  logic [15:0] rx_elapsed_q, rx_elapsed_d;
  logic        link_seen_q, link_seen_d;
  logic        lost_rep_q, lost_rep_d;

  logic [15:0] limit, timer_inc;
  logic [2:0]  maxa;
  logic        online, frame_match, finish, lost;
  rcode_e      fin_code;
  res_wr_t     wr;
  q_ctl_t      qc;

  assign fire       = item_vld_q && space_i;
  assign in_i.ready = !item_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.opcode            <= in_i.opcode;
      item_q.frame_type        <= in_i.frame_type;
      item_q.frame_length      <= in_i.frame_length;
      item_q.frame_first_byte  <= in_i.frame_first_byte;
      item_q.frame_second_byte <= in_i.frame_second_byte;
      item_q.frame_sequence    <= in_i.frame_sequence;
      item_q.command_id        <= in_i.command_id;
    end
  end

  assign limit     = (cfg_i.ack_timeout == '0) ? 16'd1 : cfg_i.ack_timeout;
  assign maxa      = (cfg_i.max_attempts == '0) ? 3'd1 : cfg_i.max_attempts;
  assign online    = link_seen_q && (rx_elapsed_q < cfg_i.online_timeout);
  assign timer_inc = (ack_timer_q == '1) ? ack_timer_q : ack_timer_q + 16'd1;

  assign frame_match = busy_q
                    && ((item_q.frame_type == cfg_i.ack_type)
                        || (item_q.frame_type == cfg_i.nack_type))
                    && (item_q.frame_length >= 8'd2)
                    && (item_q.frame_first_byte == cfg_i.ctrl_type)
                    && (item_q.frame_sequence == wait_seq_q);

  always_comb begin
    next_seq_d   = next_seq_q;
    busy_d       = busy_q;
    wait_seq_d   = wait_seq_q;
    cur_id_d     = cur_id_q;
    att_d        = att_q;
    ack_timer_d  = ack_timer_q;
    rx_elapsed_d = rx_elapsed_q;
    link_seen_d  = link_seen_q;
    lost_rep_d   = lost_rep_q;
    finish       = 1'b0;
    fin_code     = RC_OK;
    lost         = 1'b0;
    wr           = '0;
    qc           = '0;
    qc.data      = '{seq: next_seq_q, id: item_q.command_id};

    if (fire) begin
      unique case (item_q.opcode)
        OP_TICK: begin
          rx_elapsed_d = (rx_elapsed_q == '1) ? rx_elapsed_q : rx_elapsed_q + 16'd1;
          if (busy_q) begin
            ack_timer_d = timer_inc;
            if (timer_inc >= limit) begin
              if (att_q < maxa) begin
                att_d       = att_q + 3'd1;
                ack_timer_d = '0;
                wr.v0       = 1'b1;
                wr.r0       = mk_res(KIND_TX, wait_seq_q, cur_id_q, att_q + 3'd1,
                                     RC_OK, 1'b0);
              end else begin
                finish   = 1'b1;
                fin_code = RC_TIMEOUT;
              end
            end
          end
        end
        OP_FRAME: begin
          rx_elapsed_d = '0;
          link_seen_d  = 1'b1;
          lost_rep_d   = 1'b0;
          if (frame_match) begin
            finish   = 1'b1;
            fin_code = ((item_q.frame_type == cfg_i.ack_type)
                        && (item_q.frame_second_byte == '0)) ? RC_OK : RC_REJECTED;
          end
        end
        OP_SUBMIT: begin
          next_seq_d = next_seq_q + 16'd1;
          wr.v0      = 1'b1;
          if (!online) begin
            wr.r0 = mk_res(KIND_RESULT, next_seq_q, item_q.command_id, 3'd0,
                           RC_OFFLINE, 1'b0);
          end else if (pend_cnt_i == CntW'(QUEUE_DEPTH)) begin
            wr.r0 = mk_res(KIND_RESULT, next_seq_q, item_q.command_id, 3'd0,
                           RC_QUEUE_FULL, 1'b0);
          end else begin
            wr.r0 = mk_res(KIND_ACCEPTED, next_seq_q, item_q.command_id, 3'd0,
                           RC_OK, 1'b0);
            if (busy_q) begin
              qc.push = 1'b1;
            end else begin
              // idle engine has an empty queue: start this command directly
              busy_d      = 1'b1;
              wait_seq_d  = next_seq_q;
              cur_id_d    = item_q.command_id;
              att_d       = 3'd1;
              ack_timer_d = '0;
              wr.v1       = 1'b1;
              wr.r1       = mk_res(KIND_TX, next_seq_q, item_q.command_id, 3'd1,
                                   RC_OK, 1'b0);
            end
          end
        end
        OP_POLL: begin
          if (link_seen_q && !online && !lost_rep_q) begin
            lost_rep_d = 1'b1;
            lost       = 1'b1;
          end
          wr.v0 = 1'b1;
          wr.r0 = mk_res(KIND_POLL, 16'd0, 8'd0, 3'd0, RC_OK, lost);
        end
        default: ;
      endcase

      if (finish) begin
        wr.v0       = 1'b1;
        wr.r0       = mk_res(KIND_RESULT, wait_seq_q, cur_id_q, att_q, fin_code, 1'b0);
        busy_d      = 1'b0;
        wait_seq_d  = '0;
        ack_timer_d = '0;
        if (pend_cnt_i != '0) begin
          qc.pop      = 1'b1;
          busy_d      = 1'b1;
          wait_seq_d  = head_i.seq;
          cur_id_d    = head_i.id;
          att_d       = 3'd1;
          wr.v1       = 1'b1;
          wr.r1       = mk_res(KIND_TX, head_i.seq, head_i.id, 3'd1, RC_OK, 1'b0);
        end
      end

      if (wr.v1) begin
        wr.r1.last = 1'b1;
      end else begin
        wr.r0.last = 1'b1;
      end
    end
  end

  assign res_wr_o = wr;
  assign q_ctl_o  = qc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq_q   <= NEXT_SEQ_RST;
      busy_q       <= 1'b0;
      wait_seq_q   <= '0;
      cur_id_q     <= '0;
      att_q        <= '0;
      ack_timer_q  <= '0;
      rx_elapsed_q <= '0;
      link_seen_q  <= 1'b0;
      lost_rep_q   <= 1'b0;
    end else begin
      next_seq_q   <= next_seq_d;
      busy_q       <= busy_d;
      wait_seq_q   <= wait_seq_d;
      cur_id_q     <= cur_id_d;
      att_q        <= att_d;
      ack_timer_q  <= ack_timer_d;
      rx_elapsed_q <= rx_elapsed_d;
      link_seen_q  <= link_seen_d;
      lost_rep_q   <= lost_rep_d;
    end
  end

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (pend_cnt_i == '0))
    else $error("engine idle while commands are queued");

  a_busy_attempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (att_q != '0))
    else $error("engine busy with no transmission made");

endmodule

`default_nettype wire

// ----- rtl/core/command_ack_retry_engine.sv -----
// ----------------------------------------------------------------------------
// command_ack_retry_engine
// Stop-and-wait command sender with ACK timeout, retransmit and link watchdog.
// ----------------------------------------------------------------------------
// Events (ms ticks, parsed frames, submits, polls) enter through a one-item
// input register and are processed from it once the result buffer has room;
// results pass from there into a four-entry result buffer. An item that
// yields at most one result can be transferred every cycle while the buffer
// keeps room. A submit that starts an idle engine, and an ACK, NACK or final
// timeout with a further command queued, yield two results and hold the
// result port for both; the input stalls only when the buffer has fewer than
// two free entries. Pending commands sit in a QUEUE_DEPTH-entry FIFO with a
// registered head read; no clearing pass.
// Configuration writes are taken in every cycle and must be made while idle.
`default_nettype none

module command_ack_retry_engine import cmdack_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cmdack_cfg_if.sink    cfg_i,
  cmdack_in_if.sink     in_i,
  cmdack_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cfg_t            cfg;
  q_ctl_t          q_ctl;
  pend_t           head;
  logic [CntW-1:0] pend_cnt;
  res_wr_t         res_wr;
  logic            space;

  cmdack_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  cmdack_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (q_ctl),
    .head_o  (head),
    .count_o (pend_cnt)
  );

  cmdack_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg),
    .space_i    (space),
    .head_i     (head),
    .pend_cnt_i (pend_cnt),
    .q_ctl_o    (q_ctl),
    .res_wr_o   (res_wr)
  );

  cmdack_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ----- verif/cmdack_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdack_checker
// Watches the config, event and result channels of the command/ACK engine.
// It keeps its own copy of the engine state, works out the results due for
// each event transfer and compares every result transfer with the oldest one.
// ----------------------------------------------------------------------------
module cmdack_checker import cmdack_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cmdack_cfg_if        cfg_i,
  cmdack_in_if         ev_i,
  cmdack_out_if        res_i,
  output int           errors_o,
  output int           outstanding_o,
  output int           checked_o,
  output logic [15:0]  busy_seq_o
);

  localparam int unsigned MAX_PRINTED = 30;

  // engine copy
  cfg_t        cfg_m;
  pend_t       pend_q[$];
  logic [15:0] seq_next;
  logic [15:0] wait_seq;
  logic [7:0]  cur_id;
  logic [2:0]  tries;
  logic [15:0] ack_cnt;
  logic [15:0] rx_age;
  logic        in_flight;
  logic        seen;
  logic        lost_told;

  res_t step_q[$];
  res_t due_q[$];

  task automatic flag_error(string msg);
    errors_o++;
    if (errors_o <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      flag_error($sformatf("result %0d: %s is %0h, expected %0h", checked_o, name, got, want));
    end
  endtask

  function automatic void clear_model();
    cfg_m.ack_timeout    = ACK_TIMEOUT_RST;
    cfg_m.max_attempts   = MAX_ATTEMPTS_RST;
    cfg_m.online_timeout = ONLINE_TIMEOUT_RST;
    cfg_m.ctrl_type      = CTRL_TYPE_RST;
    cfg_m.ack_type       = ACK_TYPE_RST;
    cfg_m.nack_type      = NACK_TYPE_RST;
    pend_q.delete();
    due_q.delete();
    seq_next  = NEXT_SEQ_RST;
    wait_seq  = '0;
    cur_id    = '0;
    tries     = '0;
    ack_cnt   = '0;
    rx_age    = '0;
    in_flight = 1'b0;
    seen      = 1'b0;
    lost_told = 1'b0;
    errors_o  = 0;
    checked_o = 0;
  endfunction

  function automatic logic link_up();
    return seen && (rx_age < cfg_m.online_timeout);
  endfunction

  function automatic void post_result(kind_e k, logic [15:0] s, logic [7:0] id,
                                      logic [2:0] a, rcode_e c, logic l);
    res_t r;
    r.kind         = k;
    r.sequence_res = s;
    r.result_id    = id;
    r.attempts     = a;
    r.result_code  = c;
    r.link_lost    = l;
    r.last         = 1'b0;
    step_q.push_back(r);
  endfunction

  // an idle engine takes the oldest queued command and sends it
  function automatic void launch_next();
    pend_t e;
    if (in_flight || pend_q.size() == 0) return;
    e         = pend_q.pop_front();
    wait_seq  = e.seq;
    cur_id    = e.id;
    tries     = 3'd1;
    ack_cnt   = '0;
    in_flight = 1'b1;
    post_result(KIND_TX, wait_seq, cur_id, tries, RC_OK, 1'b0);
  endfunction

  function automatic void retire(rcode_e code);
    post_result(KIND_RESULT, wait_seq, cur_id, tries, code, 1'b0);
    in_flight = 1'b0;
    wait_seq  = '0;
    ack_cnt   = '0;
    launch_next();
  endfunction

  function automatic void advance_engine(item_t it);
    logic [15:0] new_seq;
    logic [15:0] limit;
    logic [2:0]  maxa;
    logic        lost;
    res_t        r;
    step_q.delete();
    case (opcode_e'(it.opcode))
      OP_TICK: begin
        if (rx_age != 16'hFFFF) rx_age++;
        if (in_flight) begin
          // zero timeout and zero attempts both behave as one
          limit = (cfg_m.ack_timeout == 16'd0) ? 16'd1 : cfg_m.ack_timeout;
          maxa  = (cfg_m.max_attempts == 3'd0) ? 3'd1 : cfg_m.max_attempts;
          if (ack_cnt != 16'hFFFF) ack_cnt++;
          if (ack_cnt >= limit) begin
            if (tries < maxa) begin
              tries++;
              ack_cnt = '0;
              post_result(KIND_TX, wait_seq, cur_id, tries, RC_OK, 1'b0);
            end else begin
              retire(RC_TIMEOUT);
            end
          end
        end
      end
      OP_FRAME: begin
        rx_age    = '0;
        seen      = 1'b1;
        lost_told = 1'b0;
        if (in_flight && (it.frame_type == cfg_m.ack_type || it.frame_type == cfg_m.nack_type)
            && it.frame_length >= 8'd2 && it.frame_first_byte == cfg_m.ctrl_type
            && it.frame_sequence == wait_seq) begin
          retire((it.frame_type == cfg_m.ack_type && it.frame_second_byte == 8'd0) ?
                 RC_OK : RC_REJECTED);
        end
      end
      OP_SUBMIT: begin
        // a refused submit still uses up its sequence number
        new_seq  = seq_next;
        seq_next = seq_next + 16'd1;
        if (!link_up()) begin
          post_result(KIND_RESULT, new_seq, it.command_id, 3'd0, RC_OFFLINE, 1'b0);
        end else if (pend_q.size() >= DEPTH) begin
          post_result(KIND_RESULT, new_seq, it.command_id, 3'd0, RC_QUEUE_FULL, 1'b0);
        end else begin
          pend_q.push_back('{seq: new_seq, id: it.command_id});
          post_result(KIND_ACCEPTED, new_seq, it.command_id, 3'd0, RC_OK, 1'b0);
          launch_next();
        end
      end
      default: begin
        lost = 1'b0;
        if (seen && !link_up() && !lost_told) begin
          lost_told = 1'b1;
          lost      = 1'b1;
        end
        post_result(KIND_POLL, 16'd0, 8'd0, 3'd0, RC_OK, lost);
      end
    endcase
    if (step_q.size() > 0) begin
      r      = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) due_q.push_back(step_q[i]);
  endfunction

  initial begin
    clear_model();
    outstanding_o = 0;
    busy_seq_o    = '0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    res_t  e;
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_ACK_TIMEOUT:    cfg_m.ack_timeout    = cfg_i.data;
          CFG_MAX_ATTEMPTS:   cfg_m.max_attempts   = cfg_i.data[2:0];
          CFG_ONLINE_TIMEOUT: cfg_m.online_timeout = cfg_i.data;
          CFG_CTRL_TYPE:      cfg_m.ctrl_type      = cfg_i.data[7:0];
          CFG_ACK_TYPE:       cfg_m.ack_type       = cfg_i.data[7:0];
          CFG_NACK_TYPE:      cfg_m.nack_type      = cfg_i.data[7:0];
          default: ;
        endcase
      end
      if (ev_i.valid && ev_i.ready) begin
        it = '{opcode: ev_i.opcode, frame_type: ev_i.frame_type,
               frame_length: ev_i.frame_length, frame_first_byte: ev_i.frame_first_byte,
               frame_second_byte: ev_i.frame_second_byte,
               frame_sequence: ev_i.frame_sequence, command_id: ev_i.command_id};
        advance_engine(it);
      end
      if (res_i.valid && res_i.ready) begin
        checked_o++;
        if (due_q.size() == 0) begin
          flag_error($sformatf("result %0d not due: kind %0d seq %0h", checked_o,
                               res_i.kind, res_i.sequence_res));
        end else begin
          e = due_q.pop_front();
          check_field("kind", 16'(res_i.kind), 16'(e.kind));
          check_field("sequence", res_i.sequence_res, e.sequence_res);
          check_field("id", 16'(res_i.result_id), 16'(e.result_id));
          check_field("attempts", 16'(res_i.attempts), 16'(e.attempts));
          check_field("code", 16'(res_i.result_code), 16'(e.result_code));
          check_field("link_lost", 16'(res_i.link_lost), 16'(e.link_lost));
          check_field("last", 16'(res_i.last), 16'(e.last));
        end
      end
    end
    outstanding_o = due_q.size();
    busy_seq_o    = wait_seq;
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the command/ACK retry engine. A few submits are
// refused while the link was never seen, a directed part walks through ACK,
// NACK, retransmit, timeout, queue full, offline and link loss, then random
// phases under changing settings and back-pressure. The checker compares.
// ----------------------------------------------------------------------------
module tb;
  import cmdack_pkg::*;

  localparam int unsigned CLK_PERIOD      = 4;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned OFFLINE_SUBMITS = 12;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 82;
  localparam int unsigned DRAIN_LIMIT     = 5000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cmdack_cfg_if cfg_if ();
  cmdack_in_if  ev_if ();
  cmdack_out_if res_if ();

  int          errors;
  int          outstanding;
  int          checked;
  logic [15:0] busy_seq;

  idle_e       mode = IDLE_NONE;
  int          cycles = 0;
  int          n_events = 0;
  int          n_submits = 0;
  int          n_writes = 0;
  logic [15:0] seq_next = NEXT_SEQ_RST;
  logic [7:0]  cur_ctrl = CTRL_TYPE_RST;
  logic [7:0]  cur_ack  = ACK_TYPE_RST;
  logic [7:0]  cur_nack = NACK_TYPE_RST;

  command_ack_retry_engine #(.QUEUE_DEPTH(QUEUE_DEPTH_DEF)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (ev_if),
    .out_o  (res_if)
  );

  cmdack_checker #(.DEPTH(QUEUE_DEPTH_DEF)) i_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_if),
    .ev_i          (ev_if),
    .res_i         (res_if),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .busy_seq_o    (busy_seq)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, outstanding);
      $display("tb: errors");
      $finish;
    end
  end

  // result back-pressure
  always @(posedge clk_i) begin
    if (mode == IDLE_RECV) begin
      res_if.ready <= ($urandom_range(99) >= 46);
    end else if (mode == IDLE_BOTH) begin
      res_if.ready <= ($urandom_range(99) >= 18);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  function automatic item_t plain_event(opcode_e op, logic [7:0] id);
    item_t it;
    it            = '0;
    it.opcode     = op;
    it.command_id = id;
    return it;
  endfunction

  function automatic item_t frame_event(logic [7:0] ftype, logic [7:0] flen, logic [7:0] b0,
                                        logic [7:0] b1, logic [15:0] fseq);
    item_t it;
    it                   = '0;
    it.opcode            = OP_FRAME;
    it.frame_type        = ftype;
    it.frame_length      = flen;
    it.frame_first_byte  = b0;
    it.frame_second_byte = b1;
    it.frame_sequence    = fseq;
    return it;
  endfunction

  // ticks, frames, submits and polls; frames mostly ACK/NACK aimed at the command in flight, the rest noise
  function automatic item_t random_event();
    item_t       it;
    logic [63:0] raw;
    int unsigned r;
    raw = {$urandom, $urandom};
    it  = raw[$bits(item_t)-1:0];
    r   = $urandom_range(99);
    if (r < 30) begin
      it.opcode = OP_TICK;
    end else if (r < 58) begin
      it.opcode = OP_FRAME;
      if ($urandom_range(9) < 7) begin
        it.frame_type   = $urandom_range(1) ? cur_ack : cur_nack;
        it.frame_length = ($urandom_range(9) == 0) ? 8'($urandom_range(1))
                                                   : 8'($urandom_range(2, 255));
        if ($urandom_range(19) != 0) it.frame_first_byte = cur_ctrl;
        if ($urandom_range(1) == 0) it.frame_second_byte = 8'd0;
        it.frame_sequence = ($urandom_range(3) == 0) ? seq_next - 16'($urandom_range(1, 4))
                                                     : busy_seq;
      end
    end else if (r < 88) begin
      it.opcode = OP_SUBMIT;
    end else begin
      it.opcode = OP_POLL;
    end
    return it;
  endfunction

  task automatic send(item_t it);
    int unsigned pct;
    int unsigned gap;
    pct = (mode == IDLE_SEND) ? 46 : (mode == IDLE_BOTH) ? 18 : 0;
    gap = 0;
    while ($urandom_range(99) < pct && gap < 20) gap++;
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ev_if.valid             <= 1'b1;
    ev_if.opcode            <= it.opcode;
    ev_if.frame_type        <= it.frame_type;
    ev_if.frame_length      <= it.frame_length;
    ev_if.frame_first_byte  <= it.frame_first_byte;
    ev_if.frame_second_byte <= it.frame_second_byte;
    ev_if.frame_sequence    <= it.frame_sequence;
    ev_if.command_id        <= it.command_id;
    do @(posedge clk_i); while (!ev_if.ready);
    n_events++;
    if (it.opcode == OP_SUBMIT) begin
      n_submits++;
      seq_next++;
    end
  endtask

  // waits until no results are due, sampling the count on the falling clock edge
  task automatic wait_drained();
    ev_if.valid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    n_writes++;
  endtask

  task automatic set_config(logic [15:0] ack_to, logic [2:0] tries, logic [15:0] online,
                            logic [7:0] ctrl, logic [7:0] ack, logic [7:0] nack);
    // a tick or a stray frame may still be in flight with nothing due
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_ACK_TIMEOUT, ack_to);
    write_reg(CFG_MAX_ATTEMPTS, 16'(tries));
    write_reg(CFG_ONLINE_TIMEOUT, online);
    write_reg(CFG_CTRL_TYPE, 16'(ctrl));
    write_reg(CFG_ACK_TYPE, 16'(ack));
    write_reg(CFG_NACK_TYPE, 16'(nack));
    cfg_if.valid <= 1'b0;
    cur_ctrl = ctrl;
    cur_ack  = ack;
    cur_nack = nack;
  endtask

  initial begin
    logic [7:0]  code;
    logic [15:0] base;
    int          guard;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = '0;
    cfg_if.data             = '0;
    ev_if.valid             = 1'b0;
    ev_if.opcode            = '0;
    ev_if.frame_type        = '0;
    ev_if.frame_length      = '0;
    ev_if.frame_first_byte  = '0;
    ev_if.frame_second_byte = '0;
    ev_if.frame_sequence    = '0;
    ev_if.command_id        = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // link never seen: every submit is refused as offline
    repeat (OFFLINE_SUBMITS) send(plain_event(OP_SUBMIT, 8'($urandom_range(255))));

    set_config(16'd1, 3'd2, 16'd4, CTRL_TYPE_RST, ACK_TYPE_RST, NACK_TYPE_RST);
    send(plain_event(OP_POLL, 8'd0));
    send(frame_event(8'd0, 8'd0, 8'd0, 8'd0, 16'd0));
    base = seq_next;
    send(plain_event(OP_SUBMIT, 8'hFF));
    send(plain_event(OP_SUBMIT, 8'h00));
    send(plain_event(OP_SUBMIT, 8'hA5));
    // near misses on the command in flight
    send(frame_event(ACK_TYPE_RST, 8'd1, CTRL_TYPE_RST, 8'd0, base));
    send(frame_event(ACK_TYPE_RST, 8'd2, 8'hFE, 8'd0, base));
    send(frame_event(8'h55, 8'd2, CTRL_TYPE_RST, 8'd0, base));
    send(frame_event(ACK_TYPE_RST, 8'd2, CTRL_TYPE_RST, 8'd0, base + 16'd1));
    send(frame_event(ACK_TYPE_RST, 8'd2, CTRL_TYPE_RST, 8'd0, base));
    send(frame_event(NACK_TYPE_RST, 8'hFF, CTRL_TYPE_RST, 8'd0, base + 16'd1));
    send(frame_event(ACK_TYPE_RST, 8'd2, CTRL_TYPE_RST, 8'hFF, base + 16'd2));
    send(plain_event(OP_SUBMIT, 8'h01));
    send(plain_event(OP_TICK, 8'd0));
    send(plain_event(OP_TICK, 8'd0));
    // one in flight, eight queued, the tenth finds the queue full
    repeat (10) send(plain_event(OP_SUBMIT, 8'($urandom_range(255))));
    send(plain_event(OP_TICK, 8'd0));
    send(plain_event(OP_TICK, 8'd0));
    send(plain_event(OP_POLL, 8'd0));
    send(plain_event(OP_POLL, 8'd0));
    send(plain_event(OP_SUBMIT, 8'h3C));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(16'd1, 3'd1, 16'hFFFF, 8'h00, 8'hFF, 8'h80);
        1: set_config(16'd0, 3'd0, 16'd1, 8'hFF, 8'h00, 8'hFF);
        2: set_config(16'hFFFF, 3'd7, 16'd40, CTRL_TYPE_RST, ACK_TYPE_RST, NACK_TYPE_RST);
        3: begin
          // ACK and NACK share one type code
          code = 8'($urandom_range(255));
          set_config(16'd3, 3'd4, 16'($urandom_range(10, 100)), 8'($urandom_range(255)),
                     code, code);
        end
        default: begin
          set_config(($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6)),
                     3'($urandom_range(1, 7)),
                     ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(8, 200)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        end
      endcase
      mode = idle_e'(p % 4);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2 || $urandom_range(59) == 0) wait_drained();
        send(random_event());
      end
    end

    ev_if.valid <= 1'b0;
    guard = 0;
    do begin
      @(negedge clk_i);
      guard++;
    end while (outstanding != 0 && guard < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("summary: %0d events (%0d submits), %0d config writes",
             n_events, n_submits, n_writes);
    $display("summary: %0d results checked over %0d setting phases, %0d left unmatched",
             checked, PHASES + 1, outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cmdack_pkg.sv
rtl/core/cmdack_if.sv
rtl/core/cmdack_cfg.sv
rtl/core/cmdack_queue.sv
rtl/core/cmdack_outbuf.sv
rtl/core/cmdack_engine.sv
rtl/core/command_ack_retry_engine.sv
verif/cmdack_checker.sv
verif/tb.sv
